### hw/rtl/oal_pkg.sv
// ----------------------------------------------------------------------------
// oal_pkg: shared definitions of the ordered array list
// Request and status codes, default sizes and the per-cell control group.
// ----------------------------------------------------------------------------
package oal_pkg;

  localparam int CAPACITY_DEF    = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  // Port field widths
  localparam int REQ_W    = 2;
  localparam int IN_VAL_W = 32;
  localparam int IN_POS_W = 5;
  localparam int STAT_W   = 2;
  localparam int OUT_IDX_W = 4;
  localparam int OUT_CNT_W = 5;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SORTED = 2'd2;
  localparam logic [REQ_W-1:0] REQ_LOCATE = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_POS   = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

  // Control broadcast to every cell
  typedef struct packed {
    logic load;    // capture compare flag against the probe value
    logic sorted;  // flag is "entry >= probe" (signed), else "entry == probe"
    logic ins;     // open a slot at the shift position
    logic del;     // close the slot at the shift position
  } cell_ctrl_t;

endpackage

### hw/rtl/oal_cell.sv
// ----------------------------------------------------------------------------
// oal_cell: one slot of the list
// Holds one entry and its compare flag; shifts with its neighbors.
// ----------------------------------------------------------------------------
module oal_cell #(
  parameter int VW  = 32,
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  logic               clk,
  input  oal_pkg::cell_ctrl_t ctrl,
  input  logic [CW-1:0]      pos,
  input  logic [VW-1:0]      probe_value,
  input  logic [VW-1:0]      new_value,
  input  logic [VW-1:0]      left_value,
  input  logic [VW-1:0]      right_value,
  output logic [VW-1:0]      val_o,
  output logic               hit_o
);

  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  logic [VW-1:0] val_r, val_nxt;
  logic          hit_r, hit_nxt;

  always_comb begin
    val_nxt = val_r;
    if (ctrl.ins) begin
      if (MY_IDX > pos) begin
        val_nxt = left_value;
      end else if (MY_IDX == pos) begin
        val_nxt = new_value;
      end
    end else if (ctrl.del) begin
      if (MY_IDX >= pos) begin
        val_nxt = right_value;
      end
    end
  end

  assign hit_nxt = ctrl.sorted ? ($signed(val_r) >= $signed(probe_value))
                               : (val_r == probe_value);

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    if (ctrl.load) begin
      hit_r <= hit_nxt;
    end
  end

  assign val_o = val_r;
  assign hit_o = hit_r;

endmodule

### hw/rtl/oal_first_hit.sv
// ----------------------------------------------------------------------------
// oal_first_hit: lowest set flag of the cell row
// Log-step prefix OR, isolate the first flag, encode its index.
// ----------------------------------------------------------------------------
module oal_first_hit #(
  parameter int N = 16
) (
  input  logic [N-1:0]         hits,
  output logic                 any,
  output logic [$clog2(N)-1:0] idx
);

  localparam int IW = $clog2(N);

  logic [N-1:0] pre;
  logic [N-1:0] first;

  always_comb begin
    pre = hits;
    for (int s = 0; s < IW; s++) begin
      pre = pre | (pre << (1 << s));
    end
  end

  // a flag is first when nothing below it is set
  assign first = hits & ~(pre << 1);
  assign any   = |hits;

  always_comb begin
    idx = '0;
    for (int i = 0; i < N; i++) begin
      if (first[i]) begin
        idx = idx | IW'(i);
      end
    end
  end

endmodule

### hw/rtl/ordered_array_list_core.sv
// ----------------------------------------------------------------------------
// ordered_array_list_core: packed list with positional and sorted insert
// Row of cells, one entry each, shifting in place; one request at a time.
// ----------------------------------------------------------------------------
// An accepted request moves the FSM to execute; the result register captures it at the end of execute.
// A new request is taken only from idle; cells compare in the accept cycle
//   and shift in the execute cycle, busy is high only during execute.
// The result register is free while the next request is taken; no stall input.
// Reset (rst_n low, synchronous) empties the list: the state, result strobe and fill
//   count are cleared, entries stay uninitialized and are never read at or above the count.
module ordered_array_list_core #(
  parameter int CAPACITY    = oal_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = oal_pkg::VALUE_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [oal_pkg::REQ_W-1:0]          in_req_type,
  input  logic signed [oal_pkg::IN_VAL_W-1:0] in_value,
  input  logic [oal_pkg::IN_POS_W-1:0]       in_position,
  output logic                               out_valid,
  output logic [oal_pkg::STAT_W-1:0]         out_status,
  output logic [oal_pkg::OUT_IDX_W-1:0]      out_index,
  output logic [oal_pkg::OUT_CNT_W-1:0]      out_fill_count
);

  import oal_pkg::*;

  // Count/position width: holds CAPACITY and any 5-bit port position.
  localparam int CW = ($clog2(CAPACITY + 1) > IN_POS_W) ? $clog2(CAPACITY + 1) : IN_POS_W;
  localparam int IW = $clog2(CAPACITY);
  localparam int VW = VALUE_WIDTH;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  logic               accept;
  logic signed [VW-1:0] probe;

  // request held for the execute cycle
  logic [REQ_W-1:0] req_q_r;
  logic [VW-1:0]    val_q_r;
  logic [CW-1:0]    pos_q_r;

  logic [CW-1:0]    count_r, count_nxt;

  // cell row
  cell_ctrl_t       ctrl;
  logic [CW-1:0]    shift_pos;
  logic [VW-1:0]    cell_val [CAPACITY];
  logic [CAPACITY-1:0] cell_hit;
  logic [CAPACITY-1:0] live_hit;

  logic             hit_any;
  logic [IW-1:0]    hit_idx;
  logic [CW-1:0]    hit_pos;

  // execute decision
  logic             do_ins, do_del;
  logic [STAT_W-1:0] stat_nxt;
  logic [CW-1:0]    idx_nxt;

  // result register
  logic             out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [OUT_IDX_W-1:0] out_index_r;
  logic [OUT_CNT_W-1:0] out_count_r;

  assign busy   = (state_r == ST_EXEC);
  assign accept = start & ~busy;

  // value port is sign-extended or cut to the entry width
  assign probe = VW'(in_value);

  // --------------------------------------------------------------------------
  // Control FSM: idle -> execute for one cycle -> idle
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q_r <= in_req_type;
      val_q_r <= probe;
      pos_q_r <= CW'(in_position);
    end
  end

  // --------------------------------------------------------------------------
  // Cell row. Every cell latches its compare flag at accept; during execute an
  // insert or delete opens or closes one slot, the cells past it taking a neighbor's entry.
  // --------------------------------------------------------------------------
  assign ctrl.load   = accept;
  assign ctrl.sorted = (in_req_type == REQ_SORTED);
  assign ctrl.ins    = do_ins;
  assign ctrl.del    = do_del;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VW-1:0] left_v, right_v;

    if (g == 0) begin : g_first
      assign left_v = val_q_r;  // never selected at the head
    end else begin : g_mid_l
      assign left_v = cell_val[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_v = cell_val[g];
    end else begin : g_mid_r
      assign right_v = cell_val[g+1];
    end

    oal_cell #(
      .VW  (VW),
      .CW  (CW),
      .IDX (g)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .pos         (shift_pos),
      .probe_value (probe),
      .new_value   (val_q_r),
      .left_value  (left_v),
      .right_value (right_v),
      .val_o       (cell_val[g]),
      .hit_o       (cell_hit[g])
    );
  end

  // only flags of occupied slots count
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      live_hit[i] = cell_hit[i] & (CW'(i) < count_r);
    end
  end

  oal_first_hit #(
    .N (CAPACITY)
  ) u_first_hit (
    .hits (live_hit),
    .any  (hit_any),
    .idx  (hit_idx)
  );

  // sorted insert with no entry at or above the value goes to the tail
  assign hit_pos = hit_any ? CW'(hit_idx) : count_r;

  // --------------------------------------------------------------------------
  // Execute: status, reported index, shift control and new count
  // --------------------------------------------------------------------------
  always_comb begin
    do_ins    = 1'b0;
    do_del    = 1'b0;
    shift_pos = pos_q_r;
    stat_nxt  = STAT_OK;
    idx_nxt   = '0;
    count_nxt = count_r;
    if (state_r == ST_EXEC) begin
      unique case (req_q_r)
        REQ_INSERT: begin
          // position check comes before the full check
          if (pos_q_r > count_r) begin
            stat_nxt = STAT_BAD_POS;
          end else if (count_r >= CAP_C) begin
            stat_nxt = STAT_FULL;
          end else begin
            do_ins    = 1'b1;
            idx_nxt   = pos_q_r;
            count_nxt = count_r + CW'(1);
          end
        end
        REQ_DELETE: begin
          if (pos_q_r >= count_r) begin
            stat_nxt = STAT_BAD_POS;
          end else begin
            do_del    = 1'b1;
            idx_nxt   = pos_q_r;
            count_nxt = count_r - CW'(1);
          end
        end
        REQ_SORTED: begin
          shift_pos = hit_pos;
          if (count_r >= CAP_C) begin
            stat_nxt = STAT_FULL;
          end else begin
            do_ins    = 1'b1;
            idx_nxt   = hit_pos;
            count_nxt = count_r + CW'(1);
          end
        end
        REQ_LOCATE: begin
          if (hit_any) begin
            idx_nxt = CW'(hit_idx);
          end else begin
            stat_nxt = STAT_NOT_FOUND;
          end
        end
        default: begin
          stat_nxt = STAT_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= (state_r == ST_EXEC);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EXEC) begin
      out_status_r <= stat_nxt;
      out_index_r  <= idx_nxt[OUT_IDX_W-1:0];
      out_count_r  <= count_nxt[OUT_CNT_W-1:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_index      = out_index_r;
  assign out_fill_count = out_count_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_result_follows_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_EXEC))
    else $error("result strobe without an executed request");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C)
    else $error("fill count above capacity");

  a_reject_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != STAT_OK) |-> (count_r == $past(count_r)))
    else $error("rejected request changed the fill count");

  a_reject_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != STAT_OK) |-> (out_index_r == '0))
    else $error("nonzero index on a rejected request");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_EXEC))
    else $error("accepted request did not enter execute");

endmodule

### verif/tb_ordered_array_list_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ordered_array_list_core: self-checking bench for the ordered array list
// Drives positional/sorted inserts, deletes and locates through the start/busy
// handshake, tracks the list contents in a local mirror and compares every
// result strobe field by field against the mirror's prediction.
// ----------------------------------------------------------------------------
module tb_ordered_array_list_core;
  import oal_pkg::*;

  localparam int CAP        = CAPACITY_DEF;
  localparam int STALL_MAX  = 500;   // cycles with no request and no result

  // Expected outcome of one request
  typedef struct packed {
    logic [STAT_W-1:0]    status;
    logic [OUT_IDX_W-1:0] index;
    logic [OUT_CNT_W-1:0] fill_count;
  } list_result_t;

  // All inputs known from time zero; reset held low until released below
  logic                        clk         = 1'b0;
  logic                        rst_n       = 1'b0;
  logic                        start       = 1'b0;
  logic [REQ_W-1:0]            in_req_type = REQ_LOCATE;
  logic signed [IN_VAL_W-1:0]  in_value    = '0;
  logic [IN_POS_W-1:0]         in_position = '0;
  logic                        busy;
  logic                        out_valid;
  logic [STAT_W-1:0]           out_status;
  logic [OUT_IDX_W-1:0]        out_index;
  logic [OUT_CNT_W-1:0]        out_fill_count;

  // Mirror of the list held by the block
  logic signed [IN_VAL_W-1:0]  mirror_list [CAP];
  int                          mirror_count = 0;

  list_result_t                pending_results [$];
  list_result_t                due_result;
  int                          error_count  = 0;
  int                          stall_cycles = 0;
  int                          idle_pct     = 0;  // chance of a gap before a request

  ordered_array_list_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_value       (in_value),
    .in_position    (in_position),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_index      (out_index),
    .out_fill_count (out_fill_count)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Mirror update: applies one request to the local list and returns what the
  // block has to report for it.
  // --------------------------------------------------------------------------
  function automatic void open_slot(int slot, logic signed [IN_VAL_W-1:0] value);
    for (int i = mirror_count; i > slot; i--) mirror_list[i] = mirror_list[i-1];
    mirror_list[slot] = value;
    mirror_count++;
  endfunction

  function automatic list_result_t apply_request(logic [REQ_W-1:0] req,
                                                 logic signed [IN_VAL_W-1:0] value,
                                                 logic [IN_POS_W-1:0] pos);
    list_result_t r;
    int           slot;
    r    = '0;
    r.status = STAT_OK;
    slot = 0;
    case (req)
      REQ_INSERT: begin
        // position check wins over the full check
        if (int'(pos) > mirror_count) r.status = STAT_BAD_POS;
        else if (mirror_count >= CAP) r.status = STAT_FULL;
        else begin
          slot = int'(pos);
          open_slot(slot, value);
        end
      end
      REQ_DELETE: begin
        // covers every position on an empty list
        if (int'(pos) >= mirror_count) r.status = STAT_BAD_POS;
        else begin
          slot = int'(pos);
          for (int i = slot; i < mirror_count - 1; i++) mirror_list[i] = mirror_list[i+1];
          mirror_count--;
        end
      end
      REQ_SORTED: begin
        if (mirror_count >= CAP) r.status = STAT_FULL;
        else begin
          // lands before the first entry not less than the value (signed)
          while (slot < mirror_count && mirror_list[slot] < value) slot++;
          open_slot(slot, value);
        end
      end
      default: begin
        // locate: first equal entry wins
        while (slot < mirror_count && mirror_list[slot] != value) slot++;
        if (slot == mirror_count) r.status = STAT_NOT_FOUND;
      end
    endcase
    if (r.status == STAT_OK) r.index = slot[OUT_IDX_W-1:0];
    r.fill_count = mirror_count[OUT_CNT_W-1:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver. Called at a falling edge; leaves start high on return so a
  // back-to-back request just overwrites the fields at the next falling edge.
  // An optional idle gap of random length, with start low, goes in front of the request.
  // --------------------------------------------------------------------------
  task automatic send_request(input logic [REQ_W-1:0] req,
                              input logic signed [IN_VAL_W-1:0] value,
                              input logic [IN_POS_W-1:0] pos);
    int gap;
    gap = 0;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 11);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start       <= 1'b1;
    in_req_type <= req;
    in_value    <= value;
    in_position <= pos;
    // busy read right at the edge is its pre-edge value, i.e. what the block saw
    do @(posedge clk); while (busy);
    pending_results.push_back(apply_request(req, value, pos));
    @(negedge clk);
  endtask

  // Value source: extremes, a tight cluster for duplicates, current entries,
  // and fully random words.
  function automatic logic signed [IN_VAL_W-1:0] pick_value();
    int small_val;
    small_val = $urandom_range(0, 8);
    case ($urandom_range(0, 7))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return small_val - 4;
      3, 4:    return (mirror_count > 0) ? mirror_list[$urandom_range(0, mirror_count - 1)]
                                         : $urandom;
      default: return $urandom;
    endcase
  endfunction

  // Well-formed request: positions inside the legal window for the current fill
  task automatic send_legal_request();
    int choice;
    choice = $urandom_range(0, 99);
    if (choice < 25 || (mirror_count == 0 && choice < 80))
      send_request(REQ_SORTED, pick_value(), '0);
    else if (choice < 45 || mirror_count == 0)
      send_request(REQ_INSERT, pick_value(), IN_POS_W'($urandom_range(0, mirror_count)));
    else if (choice < 80)
      send_request(REQ_DELETE, pick_value(),
                   IN_POS_W'($urandom_range(0, mirror_count - 1)));
    else
      send_request(REQ_LOCATE, pick_value(), IN_POS_W'($urandom_range(0, 31)));
  endtask

  // Noise: any code, any word, any 5-bit position
  task automatic send_noise_request();
    send_request(REQ_W'($urandom_range(0, 3)), $urandom, IN_POS_W'($urandom_range(0, 31)));
  endtask

  // --------------------------------------------------------------------------
  // Result checker: each strobe pops the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d index %0d fill_count %0d",
               out_status, out_index, out_fill_count);
        error_count++;
      end else begin
        due_result = pending_results.pop_front();
        if (out_status !== due_result.status) begin
          $error("out_status: expected %0d, got %0d", due_result.status, out_status);
          error_count++;
        end
        if (out_index !== due_result.index) begin
          $error("out_index: expected %0d, got %0d", due_result.index, out_index);
          error_count++;
        end
        if (out_fill_count !== due_result.fill_count) begin
          $error("out_fill_count: expected %0d, got %0d",
                 due_result.fill_count, out_fill_count);
          error_count++;
        end
      end
    end
  end

  // Watchdog: any cycle with an accepted request or a result resets the count
  always @(posedge clk) begin
    if ((start && !busy) || out_valid === 1'b1) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_MAX) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Empty list: locate misses, deletes and out-of-window inserts bounce
  task automatic test_empty_list();
    send_request(REQ_LOCATE, '0, '0);
    send_request(REQ_DELETE, '0, '0);
    send_request(REQ_DELETE, 32'sh7fff_ffff, 5'd31);
    send_request(REQ_INSERT, 32'sd9, 5'd1);
  endtask

  // Positional insert at head, tail and middle; delete from middle, tail, head
  task automatic test_positional_edit();
    send_request(REQ_INSERT, 32'sd100, 5'd0);
    send_request(REQ_INSERT, 32'sh7fff_ffff, 5'd1);     // append
    send_request(REQ_INSERT, 32'sh8000_0000, 5'd1);     // middle
    send_request(REQ_INSERT, -32'sd1, 5'd0);            // head
    send_request(REQ_INSERT, 32'sd5, 5'd5);             // one past the append position
    send_request(REQ_DELETE, '0, 5'd1);
    send_request(REQ_DELETE, '0, 5'd2);                 // last entry
    send_request(REQ_DELETE, '0, 5'd0);
    send_request(REQ_DELETE, '0, 5'd1);                 // pos == count
  endtask

  // Sorted insert ordering with extremes and duplicates, then locates
  task automatic test_sorted_and_locate();
    send_request(REQ_SORTED, '0, 5'd31);
    send_request(REQ_SORTED, 32'sh8000_0000, '0);
    send_request(REQ_SORTED, 32'sh7fff_ffff, '0);
    send_request(REQ_SORTED, -32'sd1, '0);
    send_request(REQ_SORTED, '0, '0);                   // duplicate goes first
    send_request(REQ_SORTED, 32'sd1, '0);
    send_request(REQ_LOCATE, '0, '0);                   // first of the duplicates
    send_request(REQ_LOCATE, 32'sh7fff_ffff, '0);
    send_request(REQ_LOCATE, 32'sh8000_0000, '0);
    send_request(REQ_LOCATE, 32'sd12345, '0);           // miss
  endtask

  // Fill to capacity with random content, poke every full-list case, drain
  task automatic test_fill_drain();
    idle_pct = 25;
    repeat (3) begin
      while (mirror_count < CAP) begin
        if ($urandom_range(0, 1)) send_request(REQ_SORTED, pick_value(), '0);
        else send_request(REQ_INSERT, pick_value(),
                          IN_POS_W'($urandom_range(0, mirror_count)));
      end
      send_request(REQ_INSERT, pick_value(), IN_POS_W'($urandom_range(0, CAP)));  // full
      send_request(REQ_SORTED, pick_value(), '0);                                // full
      send_request(REQ_INSERT, pick_value(),
                   IN_POS_W'($urandom_range(CAP + 1, 31)));                      // bad pos
      send_request(REQ_DELETE, pick_value(), IN_POS_W'(CAP));                    // pos == count
      send_request(REQ_LOCATE, mirror_list[CAP-1], '0);
      while (mirror_count > 0) begin
        if ($urandom_range(0, 3) == 0) send_request(REQ_LOCATE, pick_value(), '0);
        send_request(REQ_DELETE, pick_value(),
                     IN_POS_W'($urandom_range(0, mirror_count - 1)));
      end
    end
  endtask

  // Mostly well-formed traffic with some noise; gaps switch on and off
  task automatic test_random_mix();
    repeat (10) begin
      idle_pct = $urandom_range(0, 1) ? 35 : 0;
      repeat (25) begin
        if ($urandom_range(0, 99) < 80) send_legal_request();
        else send_noise_request();
      end
    end
  endtask

  // Closing stretch at full rate, no gaps
  task automatic test_back_to_back();
    idle_pct = 0;
    repeat (60) begin
      if ($urandom_range(0, 99) < 85) send_legal_request();
      else send_noise_request();
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    idle_pct = 20;
    test_empty_list();
    test_positional_edit();
    test_sorted_and_locate();
    test_fill_drain();
    test_random_mix();
    test_back_to_back();

    start <= 1'b0;
    // drain outstanding results; watchdog covers a hang
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
